### sv/p2r565_pkg.sv
// Shared types, codes and widths for the pixel to RGB565 rotator.
package p2r565_pkg;

	// Field widths fixed by the interface
	localparam int DIM_W = 11;
	localparam int IDX_W = 20;
	localparam int PIX_W = 16;
	localparam int BYTE_W = 8;

	// Largest value a raw dimension register can hold
	localparam int DIM_RAW_MAX = (2 ** DIM_W) - 1;

	// Source format codes
	localparam logic [1:0] FMT_RGB332 = 2'd0;
	localparam logic [1:0] FMT_RGB565 = 2'd1;
	localparam logic [1:0] FMT_RGB888 = 2'd2;
	localparam logic [1:0] FMT_RSVD   = 2'd3;

	// Rotation codes
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_FORMAT   = 2'd0;
	localparam logic [1:0] REG_WIDTH    = 2'd1;
	localparam logic [1:0] REG_HEIGHT   = 2'd2;
	localparam logic [1:0] REG_ROTATION = 2'd3;

	// Register reset values
	localparam logic [1:0]       RST_FORMAT   = FMT_RGB565;
	localparam logic [DIM_W-1:0] RST_WIDTH    = 11'd480;
	localparam logic [DIM_W-1:0] RST_HEIGHT   = 11'd800;
	localparam logic [1:0]       RST_ROTATION = ROT_0;

	// Active configuration, dimensions already clamped to the legal range
	typedef struct packed {
		logic [1:0]       fmt;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [1:0]       rot;
	} cfg_t;

endpackage

### sv/p2r565_unpack.sv
// Byte assembly, RGB565 conversion and raster position counters (stage 1).
module p2r565_unpack import p2r565_pkg::*; #(
	parameter int CW = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              restart,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              s1_valid,
	input  logic              s1_ready,
	output logic [PIX_W-1:0]  pix_s1,
	output logic [CW-1:0]     x_s1,
	output logic [CW-1:0]     y_s1,
	output logic              last_s1
);

	localparam int OW = (CW > DIM_W) ? CW : DIM_W;

	logic [1:0]        phase_q;
	logic [15:0]       partial_q;
	logic [CW-1:0]     x_q;
	logic [CW-1:0]     y_q;
	logic              s1_valid_q;

	logic              accept;
	logic              active;
	logic              complete;
	logic              emit;
	logic [PIX_W-1:0]  pixel;
	logic [OW:0]       x_nxt;
	logic [OW:0]       y_nxt;
	logic [OW:0]       w_ext;
	logic [OW:0]       h_ext;
	logic              col_end;
	logic              row_end;

	// Stage 1 moves when empty or when stage 2 takes its beat
	assign in_ready = !s1_valid_q || s1_ready;
	assign accept   = in_valid && in_ready;
	assign s1_valid = s1_valid_q;

	// Does this byte close a pixel
	always_comb begin
		unique case (cfg.fmt)
			FMT_RGB332: complete = 1'b1;
			FMT_RGB565: complete = (phase_q != 2'd0);
			FMT_RGB888: complete = phase_q[1];
			default:    complete = 1'b0;
		endcase
	end

	assign active = (cfg.fmt != FMT_RSVD);
	assign emit   = accept && active && complete;

	// Conversion to 5/6/5: RGB332 zero-padded, RGB565 passed through, RGB888 truncated
	always_comb begin
		unique case (cfg.fmt)
			FMT_RGB332: pixel = {data_byte[7:5], 2'b00, data_byte[4:2], 3'b000,
				data_byte[1:0], 3'b000};
			FMT_RGB565: pixel = {partial_q[7:0], data_byte};
			FMT_RGB888: pixel = {partial_q[15:11], partial_q[7:2], data_byte[7:3]};
			default:    pixel = '0;
		endcase
	end

	// Position bookkeeping
	assign x_nxt   = {1'b0, OW'(x_q)} + (OW+1)'(1);
	assign y_nxt   = {1'b0, OW'(y_q)} + (OW+1)'(1);
	assign w_ext   = (OW+1)'(cfg.width);
	assign h_ext   = (OW+1)'(cfg.height);
	assign col_end = (x_nxt >= w_ext);
	assign row_end = (y_nxt >= h_ext);

	// Byte phase, partial bytes and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 2'd0;
			partial_q <= '0;
			x_q       <= '0;
			y_q       <= '0;
		end else if (restart) begin
			phase_q   <= 2'd0;
			partial_q <= '0;
			x_q       <= '0;
			y_q       <= '0;
		end else if (accept && active) begin
			if (!complete) begin
				partial_q <= {partial_q[7:0], data_byte};
				phase_q   <= phase_q + 2'd1;
			end else begin
				partial_q <= '0;
				phase_q   <= 2'd0;
				if (col_end) begin
					x_q <= '0;
					y_q <= row_end ? '0 : CW'(y_nxt);
				end else begin
					x_q <= CW'(x_nxt);
				end
			end
		end
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= emit;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_ready && emit) begin
			pix_s1  <= pixel;
			x_s1    <= x_q;
			y_s1    <= y_q;
			last_s1 <= col_end && row_end;
		end
	end

	// Phase never passes the longest format
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("byte phase out of range");

	// Counters stay inside the image
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		((OW+1)'(x_q) < w_ext) && ((OW+1)'(y_q) < h_ext))
		else $error("raster position outside image");

	// Reserved format swallows bytes without a beat or a move
	a_rsvd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !active && !restart) |=> (!s1_valid_q && $stable(x_q) && $stable(phase_q)))
		else $error("reserved format changed state");

endmodule

### sv/p2r565_index.sv
// Rotated destination index (one multiply-add) and output register (stage 2).
module p2r565_index import p2r565_pkg::*; #(
	parameter int CW = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             s1_valid,
	output logic             s1_ready,
	input  logic [PIX_W-1:0] pix_s1,
	input  logic [CW-1:0]    x_s1,
	input  logic [CW-1:0]    y_s1,
	input  logic             last_s1,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] pixel_565,
	output logic [IDX_W-1:0] dest_index,
	output logic             last_pixel
);

	localparam int OW = (CW > DIM_W) ? CW : DIM_W;
	localparam int PW = OW + DIM_W + 1;

	logic             out_valid_q;
	logic [OW-1:0]    xe;
	logic [OW-1:0]    ye;
	logic [OW-1:0]    we;
	logic [OW-1:0]    he;
	logic [OW-1:0]    h_m_y;
	logic [OW-1:0]    w_m_x;
	logic [OW-1:0]    mul_a;
	logic [DIM_W-1:0] mul_b;
	logic [OW-1:0]    add_c;
	logic [PW-1:0]    idx_full;

	assign s1_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	assign xe    = OW'(x_s1);
	assign ye    = OW'(y_s1);
	assign we    = OW'(cfg.width);
	assign he    = OW'(cfg.height);
	assign h_m_y = he - OW'(1) - ye;
	assign w_m_x = we - OW'(1) - xe;

	// Every rotation reduces to a*b + c
	always_comb begin
		unique case (cfg.rot)
			ROT_90: begin
				mul_a = xe;
				mul_b = cfg.height;
				add_c = h_m_y;
			end
			ROT_180: begin
				mul_a = h_m_y;
				mul_b = cfg.width;
				add_c = w_m_x;
			end
			ROT_270: begin
				mul_a = w_m_x;
				mul_b = cfg.height;
				add_c = ye;
			end
			default: begin
				mul_a = ye;
				mul_b = cfg.width;
				add_c = xe;
			end
		endcase
	end

	assign idx_full = PW'(mul_a) * PW'(mul_b) + PW'(add_c);

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_ready) begin
			out_valid_q <= s1_valid;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (s1_ready && s1_valid) begin
			pixel_565  <= pix_s1;
			dest_index <= idx_full[IDX_W-1:0];
			last_pixel <= last_s1;
		end
	end

	// Half turn puts the last source pixel at the frame origin
	a_half_turn_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_pixel && (cfg.rot == ROT_180)) |-> (dest_index == '0))
		else $error("half turn last pixel not at index zero");

endmodule

### sv/pixel_to_rgb565_rotator_unit.sv
// Top level: configuration registers and the two-stage pixel pipeline.
//
// Usage:
//   Raw image bytes enter in raster order on the in_valid/in_ready channel
//   (data_byte). Each completed source pixel leaves as one beat on the
//   out_valid/out_ready channel carrying pixel_565, dest_index (its place in
//   the rotated frame) and last_pixel on the final pixel of the image.
//   Bytes that do not close a pixel, and all bytes under the reserved format
//   code, produce no output beat.
//   Configuration is written through cfg_we/cfg_index/cfg_data with no wait;
//   any write restarts the frame (byte phase and counters cleared). Write
//   only while the pipeline is empty.
//   A closing byte's pixel is registered in stage 1, then in the output
//   register. Throughput: one byte per clock; each stage reloads in the
//   cycle its beat moves on, so a receiver that keeps up never stalls input.
//   When the receiver stalls, the output register holds its beat, stage 1
//   fills, and in_ready drops only once both stages are full.
//   Reset clears the pipeline, the counters and restores the register
//   defaults (RGB565, 480 x 800, no rotation).
module pixel_to_rgb565_rotator_unit import p2r565_pkg::*; #(
	parameter int MAX_DIM = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [DIM_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] data_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  pixel_565,
	output logic [IDX_W-1:0]  dest_index,
	output logic              last_pixel
);

	localparam int CW = $clog2(MAX_DIM);
	localparam int DIM_CLIP = (MAX_DIM > DIM_RAW_MAX) ? DIM_RAW_MAX : MAX_DIM;

	logic [1:0]       fmt_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [1:0]       rot_q;
	cfg_t             cfg;

	logic             s1_valid;
	logic             s1_ready;
	logic [PIX_W-1:0] pix_s1;
	logic [CW-1:0]    x_s1;
	logic [CW-1:0]    y_s1;
	logic             last_s1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q    <= RST_FORMAT;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			rot_q    <= RST_ROTATION;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORMAT:   fmt_q    <= cfg_data[1:0];
				REG_WIDTH:    width_q  <= cfg_data;
				REG_HEIGHT:   height_q <= cfg_data;
				REG_ROTATION: rot_q    <= cfg_data[1:0];
				default:      fmt_q    <= fmt_q;
			endcase
		end
	end

	// Clamp a dimension into 1..MAX_DIM
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(DIM_CLIP)) begin
			r = DIM_W'(DIM_CLIP);
		end
		return r;
	endfunction

	assign cfg.fmt    = fmt_q;
	assign cfg.width  = clamp_dim(width_q);
	assign cfg.height = clamp_dim(height_q);
	assign cfg.rot    = rot_q;

	p2r565_unpack #(
		.CW(CW)
	) u_unpack (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (cfg_we),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.data_byte(data_byte),
		.s1_valid (s1_valid),
		.s1_ready (s1_ready),
		.pix_s1   (pix_s1),
		.x_s1     (x_s1),
		.y_s1     (y_s1),
		.last_s1  (last_s1)
	);

	p2r565_index #(
		.CW(CW)
	) u_index (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s1_valid  (s1_valid),
		.s1_ready  (s1_ready),
		.pix_s1    (pix_s1),
		.x_s1      (x_s1),
		.y_s1      (y_s1),
		.last_s1   (last_s1),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_565 (pixel_565),
		.dest_index(dest_index),
		.last_pixel(last_pixel)
	);

endmodule
